@@ rtl/core/hypothesis_merge_prune_normalise_top_macros.svh @@
// assertion helpers used by the top module
`ifndef HYPOTHESIS_MERGE_PRUNE_NORMALISE_TOP_MACROS_SVH
`define HYPOTHESIS_MERGE_PRUNE_NORMALISE_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define HMPN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define HMPN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/hmpn_pkg.sv @@
package hmpn_pkg;

    localparam int MAX_HYP   = 64;
    localparam int IDX_W     = $clog2(MAX_HYP);
    localparam int CNT_W     = $clog2(MAX_HYP + 1);
    localparam int WIN_W     = 32;
    localparam int W_W       = 38;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = W_W + IDX_W;
    localparam int NW_W      = FRAC_W + 1;
    localparam int POS_W     = 24;
    localparam int HEAD_W    = 16;
    localparam int KEEP_W    = 7;
    localparam int LIM_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_LIM = 2'd2;

    localparam logic [KEEP_W-1:0] RST_MAX_KEEP = 7'd8;
    localparam logic [LIM_W-1:0]  RST_POS_LIM  = 16'd512;
    localparam logic [LIM_W-1:0]  RST_HEAD_LIM = 16'd1638;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] hx;
        logic signed [HEAD_W-1:0] hy;
    } t_pose;

    typedef struct packed {
        logic [W_W-1:0] weight;
        t_pose          pose;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [LIM_W-1:0] pos_lim;
        logic [LIM_W-1:0] head_lim;
    } t_merge_lim;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SRT_RD, S_SRT_LAT, S_SRT_JRD, S_SRT_JCMP, S_SRT_WR,
        S_MA, S_MA_LAT, S_MB, S_MB_LAT, S_MB_EVAL, S_MA_END,
        S_SV, S_SV_LAT, S_SV_RD, S_SV_CMP, S_SV_WR,
        S_SUM_RD, S_SUM_ADD,
        S_OUT_RD, S_OUT_LAT, S_DIV, S_OUT_WAIT
    } t_state;

endpackage

@@ rtl/core/hypothesis_merge_prune_normalise_top.sv @@
// flow: loaded hypotheses are ranked, merged from the heaviest rank down, their
//   survivors ordered, the kept weights summed and each result normalised in turn;
//   a new set is taken only after the last result has left, and every pairwise
//   compare goes through the single read port of each entry memory
// reset: synchronous active low; clears control, counters, merge flags and registers
//   to their defaults; the entry memories are not cleared and need no sweep
`include "hypothesis_merge_prune_normalise_top_macros.svh"

module hypothesis_merge_prune_normalise_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [hmpn_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [hmpn_pkg::CFG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [hmpn_pkg::WIN_W-1:0]           i_hyp_weight,
    input  logic signed [hmpn_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [hmpn_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [hmpn_pkg::HEAD_W-1:0]   i_head_x,
    input  logic signed [hmpn_pkg::HEAD_W-1:0]   i_head_y,
    input  logic                                 i_last_hyp,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [hmpn_pkg::NW_W-1:0]            o_norm_weight,
    output logic signed [hmpn_pkg::POS_W-1:0]    o_out_x,
    output logic signed [hmpn_pkg::POS_W-1:0]    o_out_y,
    output logic signed [hmpn_pkg::HEAD_W-1:0]   o_out_head_x,
    output logic signed [hmpn_pkg::HEAD_W-1:0]   o_out_head_y,
    output logic                                 o_last_out
);

    localparam int IDX_W = hmpn_pkg::IDX_W;
    localparam int CNT_W = hmpn_pkg::CNT_W;
    localparam int W_W   = hmpn_pkg::W_W;

    hmpn_pkg::t_state r_state, n_state;

    // configuration registers
    logic [hmpn_pkg::KEEP_W-1:0] r_max_keep;
    hmpn_pkg::t_merge_lim        r_lim;

    // sequencing
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [IDX_W-1:0]              r_i, n_i;
    logic [IDX_W-1:0]              r_j, n_j;
    logic [IDX_W-1:0]              r_rank, n_rank;
    logic [CNT_W-1:0]              r_surv, n_surv;
    logic [CNT_W-1:0]              r_keep, n_keep;
    logic [hmpn_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [hmpn_pkg::MAX_HYP-1:0]  r_merged, n_merged;
    hmpn_pkg::t_entry              r_a, n_a;
    hmpn_pkg::t_entry              r_b, n_b;

    // output register
    logic                          r_ov, n_ov;
    logic [hmpn_pkg::NW_W-1:0]     r_onw, n_onw;
    hmpn_pkg::t_pose               r_opose, n_opose;
    logic                          r_olast, n_olast;

    // memory ports: a holds load order, later output order; b holds weight rank order
    logic                          w_a_we, w_b_we;
    logic [IDX_W-1:0]              w_a_waddr, w_a_raddr, w_b_waddr, w_b_raddr;
    hmpn_pkg::t_entry              w_a_wdata, w_b_wdata, w_a_rdata, w_b_rdata;

    logic                          w_similar;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [hmpn_pkg::NW_W-1:0]     w_quot;

    logic [IDX_W-1:0]              w_last_idx;
    logic [IDX_W-1:0]              w_keep_last;
    logic [CNT_W-1:0]              w_keep_cap;
    logic [W_W:0]                  w_wsum;
    logic [W_W-1:0]                w_wsat;
    hmpn_pkg::t_pose               w_in_pose;

    hmpn_ram #(.WIDTH(hmpn_pkg::ENTRY_W), .DEPTH(hmpn_pkg::MAX_HYP)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (w_a_wdata),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    hmpn_ram #(.WIDTH(hmpn_pkg::ENTRY_W), .DEPTH(hmpn_pkg::MAX_HYP)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // pair test: a is the held heavier-rank entry, b comes straight from memory
    hmpn_sim u_sim (
        .i_clk     (i_clk),
        .i_a_pose  (r_a.pose),
        .i_b_pose  (w_b_rdata.pose),
        .i_lim     (r_lim),
        .o_similar (w_similar)
    );

    hmpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_a_rdata.weight),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_last_idx  = IDX_W'(r_cnt - 1'b1);
    assign w_keep_last = IDX_W'(r_keep - 1'b1);

    // saturating merge of the two held weights
    assign w_wsum = {1'b0, r_a.weight} + {1'b0, r_b.weight};
    assign w_wsat = w_wsum[W_W] ? '1 : w_wsum[W_W-1:0];

    // max_keep of zero acts as one, above the store size as the store size
    always_comb begin
        if (r_max_keep == '0) begin
            w_keep_cap = CNT_W'(1);
        end else if (int'(r_max_keep) > hmpn_pkg::MAX_HYP) begin
            w_keep_cap = CNT_W'(hmpn_pkg::MAX_HYP);
        end else begin
            w_keep_cap = CNT_W'(r_max_keep);
        end
    end

    assign w_in_pose.x  = i_pos_x;
    assign w_in_pose.y  = i_pos_y;
    assign w_in_pose.hx = i_head_x;
    assign w_in_pose.hy = i_head_y;

    assign o_in_ready = (r_state == hmpn_pkg::S_LOAD);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_j      = r_j;
        n_rank   = r_rank;
        n_surv   = r_surv;
        n_keep   = r_keep;
        n_sum    = r_sum;
        n_merged = r_merged;
        n_a      = r_a;
        n_b      = r_b;
        n_ov     = r_ov;
        n_onw    = r_onw;
        n_opose  = r_opose;
        n_olast  = r_olast;

        w_a_we      = 1'b0;
        w_a_waddr   = r_i;
        w_a_wdata   = r_a;
        w_a_raddr   = r_i;
        w_b_we      = 1'b0;
        w_b_waddr   = r_i;
        w_b_wdata   = r_a;
        w_b_raddr   = r_i;
        w_div_start = 1'b0;

        unique case (r_state)
            hmpn_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    // items past a full store are dropped, last still closes the set
                    if (r_cnt < CNT_W'(hmpn_pkg::MAX_HYP)) begin
                        w_a_we           = 1'b1;
                        w_a_waddr        = r_cnt[IDX_W-1:0];
                        w_a_wdata.weight = W_W'(i_hyp_weight);
                        w_a_wdata.pose   = w_in_pose;
                        n_cnt            = r_cnt + 1'b1;
                    end
                    if (i_last_hyp) begin
                        n_i     = '0;
                        n_state = hmpn_pkg::S_SRT_RD;
                    end
                end
            end

            // stable ascending rank of each loaded entry, written to b at its rank
            hmpn_pkg::S_SRT_RD: begin
                w_a_raddr = r_i;
                n_state   = hmpn_pkg::S_SRT_LAT;
            end
            hmpn_pkg::S_SRT_LAT: begin
                n_a     = w_a_rdata;
                n_j     = '0;
                n_rank  = '0;
                n_state = hmpn_pkg::S_SRT_JRD;
            end
            hmpn_pkg::S_SRT_JRD: begin
                w_a_raddr = r_j;
                n_state   = hmpn_pkg::S_SRT_JCMP;
            end
            hmpn_pkg::S_SRT_JCMP: begin
                if ((w_a_rdata.weight < r_a.weight)
                    || ((w_a_rdata.weight == r_a.weight) && (r_j < r_i))) begin
                    n_rank = r_rank + 1'b1;
                end
                if (r_j == w_last_idx) begin
                    n_state = hmpn_pkg::S_SRT_WR;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = hmpn_pkg::S_SRT_JRD;
                end
            end
            hmpn_pkg::S_SRT_WR: begin
                w_b_we    = 1'b1;
                w_b_waddr = r_rank;
                w_b_wdata = r_a;
                if (r_i == w_last_idx) begin
                    n_i     = w_last_idx;
                    n_surv  = '0;
                    n_state = hmpn_pkg::S_MA;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = hmpn_pkg::S_SRT_RD;
                end
            end

            // merge pass from the heaviest rank down
            hmpn_pkg::S_MA: begin
                if (r_merged[r_i]) begin
                    if (r_i == '0) begin
                        n_state = hmpn_pkg::S_SV;
                    end else begin
                        n_i = r_i - 1'b1;
                    end
                end else begin
                    w_b_raddr = r_i;
                    n_state   = hmpn_pkg::S_MA_LAT;
                end
            end
            hmpn_pkg::S_MA_LAT: begin
                n_a = w_b_rdata;
                if (r_i == '0) begin
                    n_state = hmpn_pkg::S_MA_END;
                end else begin
                    n_j     = r_i - 1'b1;
                    n_state = hmpn_pkg::S_MB;
                end
            end
            hmpn_pkg::S_MB: begin
                if (r_merged[r_j]) begin
                    if (r_j == '0) begin
                        n_state = hmpn_pkg::S_MA_END;
                    end else begin
                        n_j = r_j - 1'b1;
                    end
                end else begin
                    w_b_raddr = r_j;
                    n_state   = hmpn_pkg::S_MB_LAT;
                end
            end
            hmpn_pkg::S_MB_LAT: begin
                // pair squares register inside the test unit this cycle
                n_b     = w_b_rdata;
                n_state = hmpn_pkg::S_MB_EVAL;
            end
            hmpn_pkg::S_MB_EVAL: begin
                if (w_similar) begin
                    if (r_a.weight < r_b.weight) begin
                        // held entry folds into the lower rank, which is written back now
                        n_merged[r_i]    = 1'b1;
                        w_b_we           = 1'b1;
                        w_b_waddr        = r_j;
                        w_b_wdata.weight = w_wsat;
                        w_b_wdata.pose   = r_b.pose;
                    end else begin
                        n_a.weight    = w_wsat;
                        n_merged[r_j] = 1'b1;
                    end
                end
                if (r_j == '0) begin
                    n_state = hmpn_pkg::S_MA_END;
                end else begin
                    n_j     = r_j - 1'b1;
                    n_state = hmpn_pkg::S_MB;
                end
            end
            hmpn_pkg::S_MA_END: begin
                w_b_we    = 1'b1;
                w_b_waddr = r_i;
                w_b_wdata = r_a;
                if (!r_merged[r_i]) begin
                    n_surv = r_surv + 1'b1;
                end
                if (r_i == '0) begin
                    n_state = hmpn_pkg::S_SV;
                end else begin
                    n_i     = r_i - 1'b1;
                    n_state = hmpn_pkg::S_MA;
                end
            end

            // stable descending rank of survivors, written to a in output order
            hmpn_pkg::S_SV: begin
                if (r_merged[r_i]) begin
                    if (r_i == w_last_idx) begin
                        n_keep  = (w_keep_cap < r_surv) ? w_keep_cap : r_surv;
                        n_i     = '0;
                        n_sum   = '0;
                        n_state = hmpn_pkg::S_SUM_RD;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    w_b_raddr = r_i;
                    n_state   = hmpn_pkg::S_SV_LAT;
                end
            end
            hmpn_pkg::S_SV_LAT: begin
                n_a     = w_b_rdata;
                n_j     = '0;
                n_rank  = '0;
                n_state = hmpn_pkg::S_SV_RD;
            end
            hmpn_pkg::S_SV_RD: begin
                w_b_raddr = r_j;
                n_state   = hmpn_pkg::S_SV_CMP;
            end
            hmpn_pkg::S_SV_CMP: begin
                if (!r_merged[r_j]
                    && ((w_b_rdata.weight > r_a.weight)
                        || ((w_b_rdata.weight == r_a.weight) && (r_j > r_i)))) begin
                    n_rank = r_rank + 1'b1;
                end
                if (r_j == w_last_idx) begin
                    n_state = hmpn_pkg::S_SV_WR;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = hmpn_pkg::S_SV_RD;
                end
            end
            hmpn_pkg::S_SV_WR: begin
                w_a_we    = 1'b1;
                w_a_waddr = r_rank;
                w_a_wdata = r_a;
                if (r_i == w_last_idx) begin
                    n_keep  = (w_keep_cap < r_surv) ? w_keep_cap : r_surv;
                    n_i     = '0;
                    n_sum   = '0;
                    n_state = hmpn_pkg::S_SUM_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = hmpn_pkg::S_SV;
                end
            end

            // sum of the kept weights
            hmpn_pkg::S_SUM_RD: begin
                w_a_raddr = r_i;
                n_state   = hmpn_pkg::S_SUM_ADD;
            end
            hmpn_pkg::S_SUM_ADD: begin
                n_sum = r_sum + hmpn_pkg::SUM_W'(w_a_rdata.weight);
                if (r_i == w_keep_last) begin
                    n_i     = '0;
                    n_state = hmpn_pkg::S_OUT_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = hmpn_pkg::S_SUM_RD;
                end
            end

            // normalize and emit one result at a time
            hmpn_pkg::S_OUT_RD: begin
                w_a_raddr = r_i;
                n_state   = hmpn_pkg::S_OUT_LAT;
            end
            hmpn_pkg::S_OUT_LAT: begin
                n_a         = w_a_rdata;
                w_div_start = 1'b1;
                n_state     = hmpn_pkg::S_DIV;
            end
            hmpn_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_ov    = 1'b1;
                    n_onw   = w_quot;
                    n_opose = r_a.pose;
                    n_olast = (r_i == w_keep_last);
                    n_state = hmpn_pkg::S_OUT_WAIT;
                end
            end
            hmpn_pkg::S_OUT_WAIT: begin
                if (i_out_ready) begin
                    n_ov = 1'b0;
                    if (r_olast) begin
                        // set done: back to an empty store
                        n_cnt    = '0;
                        n_surv   = '0;
                        n_merged = '0;
                        n_state  = hmpn_pkg::S_LOAD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = hmpn_pkg::S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = hmpn_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hmpn_pkg::S_LOAD;
            r_cnt    <= '0;
            r_surv   <= '0;
            r_merged <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_surv   <= n_surv;
            r_merged <= n_merged;
            r_ov     <= n_ov;
        end
    end

    // payload and loop registers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_rank  <= n_rank;
        r_keep  <= n_keep;
        r_sum   <= n_sum;
        r_a     <= n_a;
        r_b     <= n_b;
        r_onw   <= n_onw;
        r_opose <= n_opose;
        r_olast <= n_olast;
    end

    // configuration writes, to be made only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_keep     <= hmpn_pkg::RST_MAX_KEEP;
            r_lim.pos_lim  <= hmpn_pkg::RST_POS_LIM;
            r_lim.head_lim <= hmpn_pkg::RST_HEAD_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hmpn_pkg::CFG_MAX_KEEP: r_max_keep     <= i_cfg_data[hmpn_pkg::KEEP_W-1:0];
                hmpn_pkg::CFG_POS_LIM:  r_lim.pos_lim  <= i_cfg_data[hmpn_pkg::LIM_W-1:0];
                hmpn_pkg::CFG_HEAD_LIM: r_lim.head_lim <= i_cfg_data[hmpn_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_norm_weight = r_onw;
    assign o_out_x       = r_opose.x;
    assign o_out_y       = r_opose.y;
    assign o_out_head_x  = r_opose.hx;
    assign o_out_head_y  = r_opose.hy;
    assign o_last_out    = r_olast;

    // a new set is never taken while a result is pending
    `HMPN_ASSERT_IMPL(a_load_excl_out, o_in_ready, !r_ov)
    // merge flags are clear whenever a set is loading
    `HMPN_ASSERT_IMPL(a_flags_clear, r_state == hmpn_pkg::S_LOAD, r_merged == '0)
    // a rank never points past the loaded set
    `HMPN_ASSERT_IMPL(a_rank_bound, r_state == hmpn_pkg::S_SRT_WR, r_rank <= w_last_idx)
    // survivors never outnumber loaded entries
    `HMPN_ASSERT_IMPL(a_surv_bound, 1'b1, r_surv <= r_cnt)
    // the final transfer empties the store
    `HMPN_ASSERT_NEXT(a_set_done, r_ov && i_out_ready && r_olast,
                      (r_cnt == '0) && (r_state == hmpn_pkg::S_LOAD))

endmodule

@@ rtl/core/hmpn_ram.sv @@
module hmpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/hmpn_sim.sv @@
module hmpn_sim (
    input  logic                i_clk,
    input  hmpn_pkg::t_pose     i_a_pose,
    input  hmpn_pkg::t_pose     i_b_pose,
    input  hmpn_pkg::t_merge_lim i_lim,
    output logic                o_similar
);

    localparam int DX_W = hmpn_pkg::POS_W + 1;
    localparam int SQ_W = 2 * DX_W;
    localparam int HS_W = hmpn_pkg::HEAD_W + 2;
    localparam int L2_W = 2 * hmpn_pkg::LIM_W;

    logic signed [DX_W-1:0] w_dx;
    logic signed [DX_W-1:0] w_dy;
    logic signed [SQ_W-1:0] w_dx2;
    logic signed [SQ_W-1:0] w_dy2;
    logic signed [HS_W-1:0] w_hsum;
    logic        [SQ_W-1:0] r_dx2;
    logic        [SQ_W-1:0] r_dy2;
    logic signed [HS_W-1:0] r_hsum;
    logic        [L2_W-1:0] r_lim2;
    logic        [SQ_W:0]   w_d2;

    assign w_dx   = DX_W'(i_a_pose.x) - DX_W'(i_b_pose.x);
    assign w_dy   = DX_W'(i_a_pose.y) - DX_W'(i_b_pose.y);
    assign w_dx2  = w_dx * w_dx;
    assign w_dy2  = w_dy * w_dy;
    assign w_hsum = (HS_W'(i_a_pose.hx) - HS_W'(i_b_pose.hx))
                  + (HS_W'(i_a_pose.hy) - HS_W'(i_b_pose.hy));

    // squares are registered before the compare
    always_ff @(posedge i_clk) begin
        r_dx2  <= w_dx2;
        r_dy2  <= w_dy2;
        r_hsum <= w_hsum;
        r_lim2 <= i_lim.pos_lim * i_lim.pos_lim;
    end

    assign w_d2 = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign o_similar = (w_d2 < (SQ_W + 1)'(r_lim2))
                    && (r_hsum < $signed({2'b00, i_lim.head_lim}));

endmodule

@@ rtl/core/hmpn_div.sv @@
module hmpn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hmpn_pkg::W_W-1:0]    i_num,
    input  logic [hmpn_pkg::SUM_W-1:0]  i_den,
    output logic                        o_done,
    output logic [hmpn_pkg::NW_W-1:0]   o_quot
);

    localparam int CMP_W = hmpn_pkg::SUM_W + hmpn_pkg::NW_W - 1;
    localparam int K_W   = $clog2(hmpn_pkg::NW_W);

    logic [CMP_W-1:0]              r_rem;
    logic [hmpn_pkg::SUM_W-1:0]    r_den;
    logic [hmpn_pkg::NW_W-1:0]     r_quot;
    logic [K_W-1:0]                r_k;
    logic                          r_busy;
    logic                          r_done;
    logic [CMP_W-1:0]              w_shift;
    logic                          w_ge;

    assign w_shift = CMP_W'(r_den) << r_k;
    assign w_ge    = r_rem >= w_shift;

    // one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= CMP_W'({i_num, hmpn_pkg::FRAC_W'(0)});
                r_den  <= i_den;
                r_quot <= '0;
                r_k    <= K_W'(hmpn_pkg::NW_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem       <= r_rem - w_shift;
                    r_quot[r_k] <= 1'b1;
                end
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? '0 : r_quot;

endmodule

@@ test/hypothesis_merge_prune_normalise_top_tb.sv @@
module hypothesis_merge_prune_normalise_top_tb;
    import hmpn_pkg::*;

    // one hypothesis as it crosses the input channel
    typedef struct {
        logic [WIN_W-1:0]         w;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] hx;
        logic signed [HEAD_W-1:0] hy;
        logic                     last;
    } hyp_t;

    // one surviving hypothesis as it leaves the block
    typedef struct {
        logic [NW_W-1:0]          nw;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] hx;
        logic signed [HEAD_W-1:0] hy;
        logic                     last;
    } survivor_t;

    // directed stimulus row; typed_nw is used only where typed is set
    typedef struct {
        hyp_t            h;
        bit              typed;
        logic [NW_W-1:0] typed_nw;
    } row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [WIN_W-1:0]     i_hyp_weight;
    logic signed [POS_W-1:0]  i_pos_x;
    logic signed [POS_W-1:0]  i_pos_y;
    logic signed [HEAD_W-1:0] i_head_x;
    logic signed [HEAD_W-1:0] i_head_y;
    logic                 i_last_hyp;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [NW_W-1:0]      o_norm_weight;
    logic signed [POS_W-1:0]  o_out_x;
    logic signed [POS_W-1:0]  o_out_y;
    logic signed [HEAD_W-1:0] o_out_head_x;
    logic signed [HEAD_W-1:0] o_out_head_y;
    logic                 o_last_out;

    hypothesis_merge_prune_normalise_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_hyp_weight  (i_hyp_weight),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_head_x      (i_head_x),
        .i_head_y      (i_head_y),
        .i_last_hyp    (i_last_hyp),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_norm_weight (o_norm_weight),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_head_x  (o_out_head_x),
        .o_out_head_y  (o_out_head_y),
        .o_last_out    (o_last_out)
    );

    // shadow of the configuration registers
    logic [KEEP_W-1:0] keep_reg;
    logic [LIM_W-1:0]  pos_lim_reg;
    logic [LIM_W-1:0]  head_lim_reg;

    // shadow of the hypothesis store for the set being loaded
    logic [W_W-1:0] set_weight[MAX_HYP];
    t_pose          set_pose[MAX_HYP];
    int             set_count;

    survivor_t survivor_q[$];

    int  fail_count;
    int  items_sent;
    int  sets_done;
    int  results_seen;
    int  items_dropped;
    bit  idle_on;
    bit  long_hold_req;

    // clock, period 20
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #(200_000_000);
        $display("Verification failed");
        $finish;
    end

    // pairwise similarity as the reduction sees it
    function automatic bit is_similar(int a, int b);
        longint dx, dy, hsum, hlim;
        longint unsigned d2, plim;
        dx   = longint'(set_pose[a].x) - longint'(set_pose[b].x);
        dy   = longint'(set_pose[a].y) - longint'(set_pose[b].y);
        d2   = longint'(dx * dx) + longint'(dy * dy);
        plim = pos_lim_reg;
        hsum = (longint'(set_pose[a].hx) - longint'(set_pose[b].hx))
             + (longint'(set_pose[a].hy) - longint'(set_pose[b].hy));
        hlim = head_lim_reg;
        return (d2 < plim * plim) && (hsum < hlim);
    endfunction

    // merge, prune and normalise the loaded set, queue the survivors
    function automatic void reduce_set();
        int ord[MAX_HYP];
        int surv[MAX_HYP];
        bit merged[MAX_HYP];
        int n, cnt, keep, i, j, v, ma, mb, a, b;
        longint unsigned wa, wb, sum, wmax;
        survivor_t s;
        n    = set_count;
        cnt  = 0;
        sum  = 0;
        wmax = (longint'(1) << W_W) - 1;
        // stable ascending rank by weight
        for (i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && set_weight[ord[j-1]] > set_weight[i]) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = i;
        end
        for (i = 0; i < MAX_HYP; i++) merged[i] = 1'b0;
        // heaviest first; a merged one still absorbs lighter ones in the same pass
        for (ma = n - 1; ma >= 0; ma--) begin
            if (!merged[ma]) begin
                for (mb = ma - 1; mb >= 0; mb--) begin
                    a = ord[ma];
                    b = ord[mb];
                    if (!merged[mb] && is_similar(a, b)) begin
                        wa = set_weight[a];
                        wb = set_weight[b];
                        if (wa < wb) begin
                            merged[ma]    = 1'b1;
                            set_weight[b] = (wa + wb > wmax) ? wmax : wa + wb;
                        end else begin
                            set_weight[a] = (wa + wb > wmax) ? wmax : wa + wb;
                            merged[mb]    = 1'b1;
                        end
                    end
                end
                if (!merged[ma]) begin
                    surv[cnt] = ord[ma];
                    cnt++;
                end
            end
        end
        // stable descending order of survivors
        for (i = 1; i < cnt; i++) begin
            v = surv[i];
            j = i;
            while (j > 0 && set_weight[surv[j-1]] < set_weight[v]) begin
                surv[j] = surv[j-1];
                j--;
            end
            surv[j] = v;
        end
        keep = keep_reg;
        if (keep == 0) keep = 1;
        if (keep > MAX_HYP) keep = MAX_HYP;
        if (keep > cnt) keep = cnt;
        for (i = 0; i < keep; i++) sum += set_weight[surv[i]];
        for (i = 0; i < keep; i++) begin
            s.nw   = (sum == 0) ? '0 : NW_W'((longint'(set_weight[surv[i]]) << FRAC_W) / sum);
            s.x    = set_pose[surv[i]].x;
            s.y    = set_pose[surv[i]].y;
            s.hx   = set_pose[surv[i]].hx;
            s.hy   = set_pose[surv[i]].hy;
            s.last = (i + 1 == keep);
            survivor_q.push_back(s);
        end
        set_count = 0;
        sets_done++;
    endfunction

    // account for one accepted hypothesis
    function automatic void load_hyp(hyp_t h);
        if (set_count < MAX_HYP) begin
            set_weight[set_count]  = h.w;
            set_pose[set_count].x  = h.x;
            set_pose[set_count].y  = h.y;
            set_pose[set_count].hx = h.hx;
            set_pose[set_count].hy = h.hy;
            set_count++;
        end else begin
            items_dropped++;
        end
        if (h.last) reduce_set();
    endfunction

    // offer one hypothesis, after a random gap while idle_on is set; returns after the transfer
    task automatic send_hyp(hyp_t h);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        repeat (gap) @(negedge i_clk);
        i_hyp_weight = h.w;
        i_pos_x      = h.x;
        i_pos_y      = h.y;
        i_head_x     = h.hx;
        i_head_y     = h.hy;
        i_last_hyp   = h.last;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        load_hyp(h);
        items_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // register write, only while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MAX_KEEP: keep_reg     = val[KEEP_W-1:0];
            CFG_POS_LIM:  pos_lim_reg  = val;
            CFG_HEAD_LIM: head_lim_reg = val;
            default: ;
        endcase
    endtask

    // drain every queued survivor, then give the block time to settle
    task automatic wait_drained();
        wait (survivor_q.size() == 0);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic hyp_t mk_hyp(longint w, int x, int y, int hx, int hy, bit last);
        hyp_t h;
        h.w = w; h.x = x; h.y = y; h.hx = hx; h.hy = hy; h.last = last;
        return h;
    endfunction

    // random set; clustered sets give merges, the rest is full-range noise
    task automatic send_random_set(int n, bit clustered);
        hyp_t h;
        int cx, cy, k, dir;
        cx = int'($urandom_range(0, 16_000_000)) - 8_000_000;
        cy = int'($urandom_range(0, 16_000_000)) - 8_000_000;
        for (k = 0; k < n; k++) begin
            h.w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom;
            if (clustered) begin
                dir  = $urandom_range(0, 3);
                h.x  = cx + int'($urandom_range(0, 1200)) - 600;
                h.y  = cy + int'($urandom_range(0, 1200)) - 600;
                h.hx = (dir == 0) ? 16384 : (dir == 1) ? -16384 : 11585;
                h.hy = (dir == 2) ? 16384 : (dir == 3) ? -16384 : 0;
                h.hx = h.hx + int'($urandom_range(0, 400)) - 200;
                if (h.hx > 16384) h.hx = 16384;
                if (h.hx < -16384) h.hx = -16384;
            end else begin
                h.x  = $urandom;
                h.y  = $urandom;
                h.hx = int'($urandom_range(0, 32768)) - 16384;
                h.hy = int'($urandom_range(0, 32768)) - 16384;
            end
            h.last = (k == n - 1);
            send_hyp(h);
        end
    endtask

    // result side: random stalls, one long hold-off on request, field checks
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                // hold off long enough for the next set to back up the input
                i_out_ready   = 1'b0;
                long_hold_req = 1'b0;
                repeat (3000) @(negedge i_clk);
            end
            i_out_ready = 1'b0;
            repeat (idle_on ? $urandom_range(0, 17) : 0) @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_seen++;
            if (survivor_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                survivor_t e;
                e = survivor_q.pop_front();
                if (o_norm_weight !== e.nw) begin
                    $error("norm_weight: expected %0d, got %0d", e.nw, o_norm_weight);
                    fail_count++;
                end
                if (o_out_x !== e.x) begin
                    $error("out_x: expected %0d, got %0d", e.x, o_out_x);
                    fail_count++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y: expected %0d, got %0d", e.y, o_out_y);
                    fail_count++;
                end
                if (o_out_head_x !== e.hx) begin
                    $error("out_head_x: expected %0d, got %0d", e.hx, o_out_head_x);
                    fail_count++;
                end
                if (o_out_head_y !== e.hy) begin
                    $error("out_head_y: expected %0d, got %0d", e.hy, o_out_head_y);
                    fail_count++;
                end
                if (o_last_out !== e.last) begin
                    $error("last_out: expected %0d, got %0d", e.last, o_last_out);
                    fail_count++;
                end
            end
        end
    end

    // main stimulus
    initial begin
        row_t rows[$];
        row_t r;
        hyp_t h;
        int   k, n;
        fail_count    = 0;
        items_sent    = 0;
        sets_done     = 0;
        results_seen  = 0;
        items_dropped = 0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        set_count     = 0;
        keep_reg      = RST_MAX_KEEP;
        pos_lim_reg   = RST_POS_LIM;
        head_lim_reg  = RST_HEAD_LIM;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MAX_KEEP;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_hyp_weight  = '0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_head_x      = '0;
        i_head_y      = '0;
        i_last_hyp    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows at reset settings
        // a lone hypothesis carries the whole weight
        r.typed = 1'b1; r.typed_nw = 17'd65536;
        r.h = mk_hyp(32'hFFFF_FFFF, 8388607, -8388608, 16384, -16384, 1);
        rows.push_back(r);
        // a lone zero weight gives a zero sum
        r.typed_nw = 17'd0;
        r.h = mk_hyp(0, -8388608, 8388607, -16384, 16384, 1);
        rows.push_back(r);
        r.typed = 1'b0;
        // equal weights at one pose: tie folds the lower-ranked one
        r.h = mk_hyp(100, 0, 0, 16384, 0, 0); rows.push_back(r);
        r.h = mk_hyp(100, 10, -10, 16384, 0, 0); rows.push_back(r);
        r.h = mk_hyp(50, -5, 5, 16384, 0, 1); rows.push_back(r);
        // far apart, nothing merges
        r.h = mk_hyp(7, 100000, 0, 0, 16384, 0); rows.push_back(r);
        r.h = mk_hyp(3, -100000, 0, 0, 16384, 0); rows.push_back(r);
        r.h = mk_hyp(9, 0, 100000, 0, 16384, 0); rows.push_back(r);
        r.h = mk_hyp(1, 0, -100000, 0, 16384, 1); rows.push_back(r);
        // opposite headings: the signed sum passes one way only
        r.h = mk_hyp(1000, 0, 0, 16384, 16384, 0); rows.push_back(r);
        r.h = mk_hyp(2000, 100, 100, -16384, -16384, 0); rows.push_back(r);
        r.h = mk_hyp(1500, 200, 0, 0, -16384, 1); rows.push_back(r);
        // distance just at and just below the limit
        r.h = mk_hyp(40, 0, 0, 0, 0, 0); rows.push_back(r);
        r.h = mk_hyp(30, 512, 0, 0, 0, 0); rows.push_back(r);
        r.h = mk_hyp(20, 0, 511, 0, 0, 1); rows.push_back(r);
        foreach (rows[i]) begin
            send_hyp(rows[i].h);
            if (rows[i].typed) survivor_q[$].nw = rows[i].typed_nw;
        end
        wait_drained();

        // keep one, widest limits
        write_reg(CFG_MAX_KEEP, 16'd1);
        write_reg(CFG_POS_LIM, 16'hFFFF);
        write_reg(CFG_HEAD_LIM, 16'hFFFF);
        r.h = mk_hyp(5, 60000, 0, -16384, 0, 0); send_hyp(r.h);
        r.h = mk_hyp(6, 0, 0, 16384, 0, 0); send_hyp(r.h);
        r.h = mk_hyp(32'h8000_0000, -8388608, -8388608, 0, -16384, 1); send_hyp(r.h);
        wait_drained();
        // keep zero acts as one, narrowest limits merge nothing
        write_reg(CFG_MAX_KEEP, 16'd0);
        write_reg(CFG_POS_LIM, 16'd0);
        write_reg(CFG_HEAD_LIM, 16'd0);
        r.h = mk_hyp(3, 0, 0, 0, 0, 0); send_hyp(r.h);
        r.h = mk_hyp(3, 0, 0, 0, 0, 1); send_hyp(r.h);
        wait_drained();

        // full store of the largest input weights at one pose, with extra items dropped
        write_reg(CFG_MAX_KEEP, 16'd127);
        write_reg(CFG_POS_LIM, 16'd512);
        write_reg(CFG_HEAD_LIM, 16'd1638);
        idle_on = 1'b0;
        for (k = 0; k < MAX_HYP + 3; k++) begin
            h = mk_hyp(32'hFFFF_FFFF, 1234, -1234, 0, 16384, k == MAX_HYP + 2);
            send_hyp(h);
        end
        wait_drained();
        // full store of noise, everything kept
        write_reg(CFG_MAX_KEEP, 16'd64);
        send_random_set(MAX_HYP, 1'b0);
        wait_drained();
        idle_on = 1'b1;

        // receiver holds off while two sets follow back to back
        write_reg(CFG_MAX_KEEP, 16'd8);
        long_hold_req = 1'b1;
        send_random_set(6, 1'b1);
        send_random_set(6, 1'b1);
        wait_drained();

        // random part: mostly clustered sets, settings changed between phases
        while (items_sent < 410) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                write_reg(CFG_MAX_KEEP, $urandom_range(0, 3) == 0 ?
                          16'($urandom_range(0, 127)) : 16'($urandom_range(1, 6)));
                write_reg(CFG_POS_LIM, $urandom_range(0, 4) == 0 ?
                          16'($urandom) : 16'($urandom_range(100, 1200)));
                write_reg(CFG_HEAD_LIM, $urandom_range(0, 4) == 0 ?
                          16'($urandom) : 16'($urandom_range(0, 6000)));
            end
            idle_on = ($urandom_range(0, 4) != 0);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            send_random_set(n, $urandom_range(0, 4) != 0);
        end

        wait (survivor_q.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d hypotheses in %0d sets, %0d dropped on a full store",
                 items_sent, sets_done, items_dropped);
        $display("checked %0d surviving hypotheses field by field", results_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
